FILE: hdl/typed_call_stack_with_frame_label_index_core_defines.svh
// Assertion macros used by the checker of this block.
`ifndef TYPED_CALL_STACK_WITH_FRAME_LABEL_INDEX_CORE_DEFINES_SVH
`define TYPED_CALL_STACK_WITH_FRAME_LABEL_INDEX_CORE_DEFINES_SVH

// Checked only while out of reset.
`define TCS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcs assertion failed");

// Checked on every edge, reset included.
`define TCS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tcs assertion failed");

`endif

FILE: hdl/tcs_pkg.sv
package tcs_pkg;

  localparam int STACK_DEPTH  = 1024;
  localparam int HANDLE_WIDTH = 32;
  localparam int IDX_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W        = IDX_W + 1;
  localparam int LDEPTH_W     = 10;
  localparam int IO_HANDLE_W  = 32;
  localparam int CMP_W        = ((CNT_W > LDEPTH_W + 1) ? CNT_W : LDEPTH_W + 1) + 1;
  localparam int ENT_W        = 2 + HANDLE_WIDTH;
  localparam int POS_DEPTH    = 2 * STACK_DEPTH;

  typedef logic [2:0]             req_t;
  typedef logic [1:0]             kind_t;
  typedef logic [2:0]             status_t;
  typedef logic [IO_HANDLE_W-1:0] io_handle_t;
  typedef logic [LDEPTH_W-1:0]    ldepth_t;
  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [IDX_W:0]         pos_addr_t;
  typedef logic [ENT_W-1:0]       ent_t;

  localparam req_t REQ_PUSH      = 3'd0;
  localparam req_t REQ_POP_ANY   = 3'd1;
  localparam req_t REQ_POP_TYPED = 3'd2;
  localparam req_t REQ_PEEK      = 3'd3;
  localparam req_t REQ_FRAME     = 3'd4;
  localparam req_t REQ_LABEL     = 3'd5;

  localparam kind_t K_FRAME   = 2'd0;
  localparam kind_t K_LABEL   = 2'd1;
  localparam kind_t K_VALUE   = 2'd2;
  localparam kind_t K_INVALID = 2'd3;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_WRONG    = 3'd2;
  localparam status_t ST_MISSING  = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  // Side stack select in the position memory.
  localparam logic SEL_FRAME = 1'b0;
  localparam logic SEL_LABEL = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FETCH
  } state_t;

  function automatic handle_t handle_in(input io_handle_t h);
    logic [HANDLE_WIDTH+IO_HANDLE_W-1:0] tmp;
    tmp = {{HANDLE_WIDTH{1'b0}}, h};
    return tmp[HANDLE_WIDTH-1:0];
  endfunction

  function automatic io_handle_t handle_out(input handle_t h);
    logic [HANDLE_WIDTH+IO_HANDLE_W-1:0] tmp;
    tmp = {{IO_HANDLE_W{1'b0}}, h};
    return tmp[IO_HANDLE_W-1:0];
  endfunction

endpackage

FILE: hdl/tcs_ifs.sv
interface tcs_req_if;
  logic                 valid;
  logic                 ready;
  tcs_pkg::req_t        req_type;
  tcs_pkg::kind_t       entry_kind;
  tcs_pkg::io_handle_t  entry_handle;
  tcs_pkg::ldepth_t     label_depth;

  modport source (output valid, req_type, entry_kind, entry_handle, label_depth,
                  input ready);
  modport sink (input valid, req_type, entry_kind, entry_handle, label_depth,
                output ready);
endinterface

interface tcs_rsp_if;
  logic                 valid;
  logic                 ready;
  tcs_pkg::status_t     status;
  tcs_pkg::kind_t       out_kind;
  tcs_pkg::io_handle_t  out_handle;

  modport source (output valid, status, out_kind, out_handle, input ready);
  modport sink (input valid, status, out_kind, out_handle, output ready);
endinterface

FILE: hdl/tcs_ram.sv
module tcs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/typed_call_stack_with_frame_label_index_core.sv
// channel | dir | payload                                        | handshake
// in_req  | in  | req_type, entry_kind, entry_handle, label_depth | valid/ready
// out_rsp | out | status, out_kind, out_handle                   | valid/ready
//
// Push, pops, peek: accept with top read, then entry data in S_FETCH.
// Current frame, label at depth: position memory read at accept, entry read
// in S_LOOK, then S_FETCH; S_LOOK is skipped when the frame or label is missing.
// Reset clears the state, counts and output valid; entry and position memories need no clearing.
// A new item is taken while the previous result sits in the output register;
// an item stalls in its last step until that register is free.
module typed_call_stack_with_frame_label_index_core (
  input  logic       clk,
  input  logic       rst_n,
  tcs_req_if.sink    in_req,
  tcs_rsp_if.source  out_rsp
);

  tcs_pkg::state_t     state_r, state_nxt;
  tcs_pkg::req_t       req_r, req_nxt;
  tcs_pkg::kind_t      kind_r, kind_nxt;
  tcs_pkg::handle_t    handle_r, handle_nxt;
  tcs_pkg::status_t    pre_st_r, pre_st_nxt;
  tcs_pkg::cnt_t       stack_cnt_r, stack_cnt_nxt;
  tcs_pkg::cnt_t       frame_cnt_r, frame_cnt_nxt;
  tcs_pkg::cnt_t       label_cnt_r, label_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcs_pkg::status_t    out_status_r, out_status_nxt;
  tcs_pkg::kind_t      out_kind_r, out_kind_nxt;
  tcs_pkg::io_handle_t out_handle_r, out_handle_nxt;

  logic                accept;
  logic                fire;
  logic                drop;
  tcs_pkg::status_t    pre_st;
  tcs_pkg::cmp_t       lbl_need;
  tcs_pkg::cmp_t       lbl_pos;
  tcs_pkg::kind_t      ent_kind;
  tcs_pkg::handle_t    ent_handle;
  tcs_pkg::kind_t      top_kind;

  logic                ent_wr_en, ent_rd_en;
  tcs_pkg::idx_t       ent_wr_addr, ent_rd_addr;
  tcs_pkg::ent_t       ent_wr_data, ent_rd_data;
  logic                pos_wr_en, pos_rd_en;
  tcs_pkg::pos_addr_t  pos_wr_addr, pos_rd_addr;
  tcs_pkg::idx_t       pos_wr_data, pos_rd_data;

  // Entry and position accesses never share a cycle: reads go out at accept
  // and in S_LOOK, writes only in S_FETCH, so no forwarding is needed.
  tcs_ram #(.DEPTH(tcs_pkg::STACK_DEPTH), .WIDTH(tcs_pkg::ENT_W)) u_ent_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data)
  );

  tcs_ram #(.DEPTH(tcs_pkg::POS_DEPTH), .WIDTH(tcs_pkg::IDX_W)) u_pos_ram (
    .clk     (clk),
    .wr_en   (pos_wr_en),
    .wr_addr (pos_wr_addr),
    .wr_data (pos_wr_data),
    .rd_en   (pos_rd_en),
    .rd_addr (pos_rd_addr),
    .rd_data (pos_rd_data)
  );

  assign accept     = in_req.valid && in_req.ready;
  assign fire       = (state_r == tcs_pkg::S_FETCH) && (!out_valid_r || out_rsp.ready);
  assign ent_kind   = ent_rd_data[tcs_pkg::ENT_W-1 -: 2];
  assign ent_handle = ent_rd_data[tcs_pkg::HANDLE_WIDTH-1:0];
  assign lbl_need   = tcs_pkg::cmp_t'(in_req.label_depth) + tcs_pkg::cmp_t'(1);
  assign lbl_pos    = tcs_pkg::cmp_t'(label_cnt_r) - lbl_need;
  assign top_kind   = ent_kind;

  // early status from the request and counts
  always_comb begin
    pre_st = tcs_pkg::ST_OK;
    unique case (in_req.req_type)
      tcs_pkg::REQ_PUSH: begin
        if (in_req.entry_kind == tcs_pkg::K_INVALID) begin
          pre_st = tcs_pkg::ST_WRONG;
        end else if (stack_cnt_r == tcs_pkg::cnt_t'(tcs_pkg::STACK_DEPTH)) begin
          pre_st = tcs_pkg::ST_OVERFLOW;
        end
      end
      tcs_pkg::REQ_POP_ANY, tcs_pkg::REQ_POP_TYPED, tcs_pkg::REQ_PEEK: begin
        if (stack_cnt_r == '0) begin
          pre_st = tcs_pkg::ST_EMPTY;
        end
      end
      tcs_pkg::REQ_FRAME: begin
        if (frame_cnt_r == '0) begin
          pre_st = tcs_pkg::ST_MISSING;
        end
      end
      tcs_pkg::REQ_LABEL: begin
        if (tcs_pkg::cmp_t'(label_cnt_r) < lbl_need) begin
          pre_st = tcs_pkg::ST_MISSING;
        end
      end
      default: pre_st = tcs_pkg::ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcs_pkg::S_IDLE: begin
        if (accept) begin
          if ((in_req.req_type == tcs_pkg::REQ_FRAME ||
               in_req.req_type == tcs_pkg::REQ_LABEL) && pre_st == tcs_pkg::ST_OK) begin
            state_nxt = tcs_pkg::S_LOOK;
          end else begin
            state_nxt = tcs_pkg::S_FETCH;
          end
        end
      end
      tcs_pkg::S_LOOK:  state_nxt = tcs_pkg::S_FETCH;
      tcs_pkg::S_FETCH: begin
        if (fire) begin
          state_nxt = tcs_pkg::S_IDLE;
        end
      end
      default: state_nxt = tcs_pkg::S_IDLE;
    endcase
  end

  // outputs, memory control, counts
  always_comb begin
    in_req.ready   = (state_r == tcs_pkg::S_IDLE);
    req_nxt        = req_r;
    kind_nxt       = kind_r;
    handle_nxt     = handle_r;
    pre_st_nxt     = pre_st_r;
    stack_cnt_nxt  = stack_cnt_r;
    frame_cnt_nxt  = frame_cnt_r;
    label_cnt_nxt  = label_cnt_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    drop           = 1'b0;

    ent_rd_en   = 1'b0;
    ent_rd_addr = tcs_pkg::idx_t'(stack_cnt_r - tcs_pkg::cnt_t'(1));
    ent_wr_en   = 1'b0;
    ent_wr_addr = stack_cnt_r[tcs_pkg::IDX_W-1:0];
    ent_wr_data = {kind_r, handle_r};
    pos_rd_en   = 1'b0;
    pos_rd_addr = {tcs_pkg::SEL_FRAME,
                   tcs_pkg::idx_t'(frame_cnt_r - tcs_pkg::cnt_t'(1))};
    pos_wr_en   = 1'b0;
    pos_wr_addr = {tcs_pkg::SEL_FRAME, frame_cnt_r[tcs_pkg::IDX_W-1:0]};
    pos_wr_data = stack_cnt_r[tcs_pkg::IDX_W-1:0];

    if (in_req.req_type == tcs_pkg::REQ_LABEL) begin
      pos_rd_addr = {tcs_pkg::SEL_LABEL, lbl_pos[tcs_pkg::IDX_W-1:0]};
    end
    if (kind_r == tcs_pkg::K_LABEL) begin
      pos_wr_addr = {tcs_pkg::SEL_LABEL, label_cnt_r[tcs_pkg::IDX_W-1:0]};
    end

    if (accept) begin
      req_nxt    = in_req.req_type;
      kind_nxt   = in_req.entry_kind;
      handle_nxt = tcs_pkg::handle_in(in_req.entry_handle);
      pre_st_nxt = pre_st;
      ent_rd_en  = 1'b1;
      pos_rd_en  = 1'b1;
    end

    if (state_r == tcs_pkg::S_LOOK) begin
      ent_rd_en   = 1'b1;
      ent_rd_addr = pos_rd_data;
    end

    if (fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = tcs_pkg::ST_OK;
      out_kind_nxt   = tcs_pkg::K_FRAME;
      out_handle_nxt = '0;
      if (pre_st_r != tcs_pkg::ST_OK) begin
        out_status_nxt = pre_st_r;
      end else begin
        unique case (req_r)
          tcs_pkg::REQ_PUSH: begin
            ent_wr_en     = 1'b1;
            stack_cnt_nxt = stack_cnt_r + tcs_pkg::cnt_t'(1);
            if (kind_r == tcs_pkg::K_FRAME) begin
              pos_wr_en     = 1'b1;
              frame_cnt_nxt = frame_cnt_r + tcs_pkg::cnt_t'(1);
            end else if (kind_r == tcs_pkg::K_LABEL) begin
              pos_wr_en     = 1'b1;
              label_cnt_nxt = label_cnt_r + tcs_pkg::cnt_t'(1);
            end
          end
          tcs_pkg::REQ_POP_ANY, tcs_pkg::REQ_FRAME, tcs_pkg::REQ_LABEL: begin
            out_kind_nxt   = ent_kind;
            out_handle_nxt = tcs_pkg::handle_out(ent_handle);
            drop           = (req_r == tcs_pkg::REQ_POP_ANY);
          end
          tcs_pkg::REQ_POP_TYPED, tcs_pkg::REQ_PEEK: begin
            if (ent_kind != kind_r) begin
              out_status_nxt = tcs_pkg::ST_WRONG;
            end else begin
              out_kind_nxt   = ent_kind;
              out_handle_nxt = tcs_pkg::handle_out(ent_handle);
              drop           = (req_r == tcs_pkg::REQ_POP_TYPED);
            end
          end
          default: out_status_nxt = tcs_pkg::ST_OK;
        endcase
      end
    end

    if (drop) begin
      stack_cnt_nxt = stack_cnt_r - tcs_pkg::cnt_t'(1);
      if (top_kind == tcs_pkg::K_FRAME && frame_cnt_r != '0) begin
        frame_cnt_nxt = frame_cnt_r - tcs_pkg::cnt_t'(1);
      end else if (top_kind == tcs_pkg::K_LABEL && label_cnt_r != '0) begin
        label_cnt_nxt = label_cnt_r - tcs_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcs_pkg::S_IDLE;
      stack_cnt_r <= '0;
      frame_cnt_r <= '0;
      label_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stack_cnt_r <= stack_cnt_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      label_cnt_r <= label_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    kind_r       <= kind_nxt;
    handle_r     <= handle_nxt;
    pre_st_r     <= pre_st_nxt;
    out_status_r <= out_status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.out_kind   = out_kind_r;
  assign out_rsp.out_handle = out_handle_r;

endmodule

FILE: hdl/tcs_checker.sv
`include "typed_call_stack_with_frame_label_index_core_defines.svh"

module tcs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tcs_pkg::status_t    status,
  input tcs_pkg::kind_t      out_kind,
  input tcs_pkg::io_handle_t out_handle
);

  // no result right after reset
  `TCS_ASSERT_ALWAYS(a_rst_no_out, clk, !rst_n |=> !out_valid)

  // the block is busy after each accept
  `TCS_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // failed requests return no entry
  `TCS_ASSERT(a_fail_no_entry, clk, rst_n, out_valid && status != tcs_pkg::ST_OK |-> out_kind == tcs_pkg::K_FRAME && out_handle == '0)

  `TCS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_handle))

endmodule

bind typed_call_stack_with_frame_label_index_core tcs_checker u_tcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .status     (out_rsp.status),
  .out_kind   (out_rsp.out_kind),
  .out_handle (out_rsp.out_handle)
);

FILE: tb/typed_call_stack_with_frame_label_index_core_test.sv
module typed_call_stack_with_frame_label_index_core_test;
  import tcs_pkg::*;

  localparam int   CYCLE_LIMIT = 400000;
  localparam int   HOLD_AT     = 200;
  localparam int   HOLD_CYCLES = 300;
  localparam req_t REQ_RSVD_LO = 3'd6;
  localparam req_t REQ_RSVD_HI = 3'd7;

  typedef struct packed {
    req_t       req;
    kind_t      kind;
    io_handle_t handle;
    ldepth_t    depth;
  } req_item_t;

  typedef struct packed {
    status_t    status;
    kind_t      kind;
    io_handle_t handle;
  } rsp_t;

  class stack_scoreboard;
    kind_t       kinds[STACK_DEPTH];
    handle_t     handles[STACK_DEPTH];
    int unsigned frame_pos[STACK_DEPTH];
    int unsigned label_pos[STACK_DEPTH];
    int unsigned depth_used;
    int unsigned frames_used;
    int unsigned labels_used;
    int unsigned peak_depth;
    int unsigned errors;
    int unsigned req_seen[8];
    int unsigned status_seen[8];
    rsp_t        expected[$];

    function rsp_t entry_at(int unsigned pos);
      rsp_t r;
      r        = '0;
      r.status = ST_OK;
      r.kind   = kinds[pos];
      r.handle = io_handle_t'(handles[pos]);
      return r;
    endfunction

    function void drop_top();
      kind_t k;
      k = kinds[depth_used - 1];
      if (k == K_FRAME && frames_used > 0) frames_used--;
      else if (k == K_LABEL && labels_used > 0) labels_used--;
      depth_used--;
    endfunction

    function void note_request(req_item_t it);
      rsp_t r;
      r        = '0;
      r.status = ST_OK;
      req_seen[it.req]++;
      case (it.req)
        REQ_PUSH: begin
          if (it.kind == K_INVALID) begin
            r.status = ST_WRONG;
          end else if (depth_used >= STACK_DEPTH) begin
            r.status = ST_OVERFLOW;
          end else begin
            kinds[depth_used]   = it.kind;
            handles[depth_used] = handle_t'(it.handle);
            if (it.kind == K_FRAME) begin
              frame_pos[frames_used] = depth_used;
              frames_used++;
            end else if (it.kind == K_LABEL) begin
              label_pos[labels_used] = depth_used;
              labels_used++;
            end
            depth_used++;
            if (depth_used > peak_depth) peak_depth = depth_used;
          end
        end
        REQ_POP_ANY: begin
          if (depth_used == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r = entry_at(depth_used - 1);
            drop_top();
          end
        end
        REQ_POP_TYPED, REQ_PEEK: begin
          if (depth_used == 0) begin
            r.status = ST_EMPTY;
          end else if (kinds[depth_used - 1] != it.kind) begin
            r.status = ST_WRONG;
          end else begin
            r = entry_at(depth_used - 1);
            if (it.req == REQ_POP_TYPED) drop_top();
          end
        end
        REQ_FRAME: begin
          if (frames_used == 0) r.status = ST_MISSING;
          else r = entry_at(frame_pos[frames_used - 1]);
        end
        REQ_LABEL: begin
          if (labels_used <= it.depth) r.status = ST_MISSING;
          else r = entry_at(label_pos[labels_used - it.depth - 1]);
        end
        default: begin
        end
      endcase
      expected = {expected, r};
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      status_seen[got.status]++;
      if (expected.size() == 0) begin
        $error("result with nothing expected: status %0d kind %0d handle %h",
               got.status, got.kind, got.handle);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.handle !== want.handle) begin
        $error("out_handle: expected %h, got %h", want.handle, got.handle);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  tcs_req_if       in_req();
  tcs_rsp_if       out_rsp();
  stack_scoreboard sb;
  int unsigned     sent_count;
  int unsigned     cycle_count;
  bit              sender_calm;

  typed_call_stack_with_frame_label_index_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(req_item_t it);
    int unsigned gap;
    if (sent_count % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.req_type     <= it.req;
    in_req.entry_kind   <= it.kind;
    in_req.entry_handle <= it.handle;
    in_req.label_depth  <= it.depth;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sb.note_request(it);
    sent_count++;
  endtask

  function automatic req_item_t rand_item(int unsigned push_pct);
    req_item_t   it;
    int unsigned top;
    it.handle = $urandom();
    it.kind   = kind_t'($urandom_range(0, 3));
    it.depth  = ldepth_t'($urandom_range(0, 1023));
    if ($urandom_range(0, 99) < push_pct) begin
      it.req  = REQ_PUSH;
      it.kind = ($urandom_range(0, 15) == 0) ? K_INVALID : kind_t'($urandom_range(0, 2));
    end else begin
      case ($urandom_range(0, 11))
        0, 1:    it.req = REQ_POP_ANY;
        2, 3:    it.req = REQ_POP_TYPED;
        4, 5:    it.req = REQ_PEEK;
        6, 7:    it.req = REQ_FRAME;
        8, 9, 10: it.req = REQ_LABEL;
        default: it.req = $urandom_range(0, 1) ? REQ_RSVD_HI : REQ_RSVD_LO;
      endcase
      // mostly ask for the kind on top so typed pops and peeks succeed
      if ((it.req == REQ_POP_TYPED || it.req == REQ_PEEK) && sb.depth_used > 0
          && $urandom_range(0, 9) < 6) begin
        top     = sb.depth_used - 1;
        it.kind = sb.kinds[top];
      end
      if (it.req == REQ_LABEL && sb.labels_used > 0 && $urandom_range(0, 1) == 1) begin
        top      = (sb.labels_used > 1024) ? 1023 : sb.labels_used - 1;
        it.depth = ldepth_t'($urandom_range(0, top));
      end
    end
    return it;
  endfunction

  task automatic run_random(int unsigned count, int unsigned push_pct);
    repeat (count) send_item(rand_item(push_pct));
  endtask

  initial begin : result_sink
    int unsigned taken;
    int unsigned gap;
    bit          calm;
    rsp_t        got;
    taken = 0;
    calm  = 1'b0;
    out_rsp.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 15);
      // long hold-off: block fills and backs up the input
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      @(posedge clk);
      while (!out_rsp.valid) @(posedge clk);
      got.status = out_rsp.status;
      got.kind   = out_rsp.out_kind;
      got.handle = out_rsp.out_handle;
      sb.check_result(got);
      taken++;
    end
  end

  initial begin
    sb = new();
    rst_n               <= 1'b0;
    in_req.valid        <= 1'b0;
    in_req.req_type     <= REQ_PUSH;
    in_req.entry_kind   <= K_FRAME;
    in_req.entry_handle <= '0;
    in_req.label_depth  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack, missing frame and label, invalid kind, typed mismatches
    send_item('{REQ_POP_ANY,   K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_POP_TYPED, K_VALUE,   32'h0000_0000, 10'd0});
    send_item('{REQ_PEEK,      K_LABEL,   32'h0000_0000, 10'd0});
    send_item('{REQ_FRAME,     K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_LABEL,     K_LABEL,   32'h0000_0000, 10'd0});
    send_item('{REQ_PUSH,      K_INVALID, 32'hffff_ffff, 10'd0});
    send_item('{REQ_PUSH,      K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_PUSH,      K_LABEL,   32'hffff_ffff, 10'd0});
    send_item('{REQ_PUSH,      K_VALUE,   32'ha5a5_a5a5, 10'd0});
    send_item('{REQ_PEEK,      K_VALUE,   32'h0000_0000, 10'd0});
    send_item('{REQ_PEEK,      K_INVALID, 32'h0000_0000, 10'd0});
    send_item('{REQ_POP_TYPED, K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_FRAME,     K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_LABEL,     K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_LABEL,     K_FRAME,   32'h0000_0000, 10'd1});
    send_item('{REQ_LABEL,     K_FRAME,   32'h0000_0000, 10'd1023});
    send_item('{REQ_PUSH,      K_LABEL,   32'h5a5a_5a5a, 10'd0});
    send_item('{REQ_LABEL,     K_FRAME,   32'h0000_0000, 10'd1});
    send_item('{REQ_RSVD_LO,   K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_RSVD_HI,   K_INVALID, 32'hffff_ffff, 10'd1023});
    send_item('{REQ_POP_TYPED, K_LABEL,   32'h0000_0000, 10'd0});
    send_item('{REQ_POP_TYPED, K_VALUE,   32'h0000_0000, 10'd0});
    send_item('{REQ_POP_ANY,   K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_POP_ANY,   K_FRAME,   32'h0000_0000, 10'd0});
    send_item('{REQ_FRAME,     K_FRAME,   32'h0000_0000, 10'd0});

    run_random(120, 45);
    while (sb.depth_used < STACK_DEPTH) send_item(rand_item(90));
    run_random(40, 60);
    run_random(130, 15);

    in_req.valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("items %0d: push %0d pop %0d tpop %0d peek %0d frame %0d label %0d other %0d",
             sent_count, sb.req_seen[REQ_PUSH], sb.req_seen[REQ_POP_ANY],
             sb.req_seen[REQ_POP_TYPED], sb.req_seen[REQ_PEEK], sb.req_seen[REQ_FRAME],
             sb.req_seen[REQ_LABEL], sb.req_seen[REQ_RSVD_LO] + sb.req_seen[REQ_RSVD_HI]);
    $display("status ok %0d empty %0d wrong %0d missing %0d overflow %0d, max depth %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_WRONG],
             sb.status_seen[ST_MISSING], sb.status_seen[ST_OVERFLOW], sb.peak_depth);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
